FILE: sv/u64dt_pkg.sv
// Package for the binary to decimal text converter.
// Holds character constants, register codes and the state types.
// No dependencies.
package u64dt_pkg;

  localparam int unsigned CAP_W   = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned APB_W   = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd21;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // Register byte addresses.
  localparam logic ADDR_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SKIP,
    B_ZERO,
    B_DIGIT
  } back_state_t;

endpackage

FILE: sv/u64dt_front.sv
// Front end: accepts values and converts them to packed BCD by shift-and-add-3.
// Depends on u64dt_pkg.
module u64dt_front #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned ENTRY_W    = 88
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [63:0]                   in_value,
  input  logic [u64dt_pkg::CAP_W-1:0]   capacity,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [ENTRY_W-1:0]            q_data
);
  import u64dt_pkg::*;

  localparam int unsigned NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned DIG_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  front_state_t state, state_next;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] bin;
  logic [DIG_W-1:0]      bcd;
  logic [DIG_W-1:0]      bcd_adj;
  logic [CAP_W-1:0]      cap;
  logic                  zero;
  logic                  accept;
  logic                  conv_done;

  assign accept    = in_valid && in_ready;
  assign conv_done = (cnt == CNT_W'(VALUE_BITS - 1));

  // Each digit of five or more gets three added before the doubling shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) state_next = F_CONV;
      F_CONV: if (conv_done) state_next = F_PUSH;
      F_PUSH: if (q_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == F_IDLE);
    q_valid  = (state == F_PUSH);
    q_data   = {zero, cap, bcd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == F_CONV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin  <= in_value[VALUE_BITS-1:0];
      bcd  <= '0;
      cap  <= capacity;
      zero <= (in_value[VALUE_BITS-1:0] == '0);
    end else if (state == F_CONV) begin
      bcd <= {bcd_adj[DIG_W-2:0], bin[VALUE_BITS-1]};
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
    end
  end

endmodule

FILE: sv/u64dt_queue.sv
// Two-entry queue between the converter and the character emitter.
// No dependencies.
module u64dt_queue #(
  parameter int unsigned W = 88
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

FILE: sv/u64dt_back.sv
// Back end: drops leading zero digits and emits characters through an output register.
// Depends on u64dt_pkg.
module u64dt_back #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned ENTRY_W    = 88
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [ENTRY_W-1:0]            q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u64dt_pkg::CHAR_W-1:0]  out_char,
  output logic                          out_last
);
  import u64dt_pkg::*;

  localparam int unsigned NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned DIG_W = 4 * NDIG;
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  back_state_t state, state_next;
  logic [DIG_W-1:0] digits;
  logic [REM_W-1:0] rem;
  logic [CAP_W-1:0] room;
  logic [3:0]       top_digit;
  logic [DIG_W-1:0] q_digits;
  logic [CAP_W-1:0] q_cap;
  logic             q_zero;
  logic             slot_free;
  logic             more_digits;
  logic             emit;
  logic [CHAR_W-1:0] emit_char;
  logic             emit_last;

  assign q_digits    = q_data[DIG_W-1:0];
  assign q_cap       = q_data[DIG_W +: CAP_W];
  assign q_zero      = q_data[DIG_W + CAP_W];
  assign top_digit   = digits[DIG_W-1 -: 4];
  assign slot_free   = !out_valid || out_ready;
  assign more_digits = (room != '0) && (rem != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && (q_cap != '0)) state_next = q_zero ? B_ZERO : B_SKIP;
      end
      B_SKIP: begin
        if (top_digit != 4'd0) state_next = B_DIGIT;
      end
      B_ZERO: begin
        if (slot_free) state_next = (room == '0) ? B_IDLE : B_DIGIT;
      end
      B_DIGIT: begin
        if (slot_free && !more_digits) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == B_IDLE);
    emit      = 1'b0;
    emit_char = CHAR_NUL;
    emit_last = 1'b0;
    unique case (state)
      B_ZERO: begin
        emit      = slot_free;
        emit_char = ASCII_ZERO;
        emit_last = (room == '0);
      end
      B_DIGIT: begin
        emit = slot_free;
        if (more_digits) begin
          emit_char = ASCII_ZERO | {4'd0, top_digit};
        end else begin
          emit_last = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          digits <= q_digits;
          rem    <= q_zero ? '0 : REM_W'(NDIG);
          room   <= q_cap - 1'b1;
        end
      end
      B_SKIP: begin
        if (top_digit == 4'd0) begin
          digits <= {digits[DIG_W-5:0], 4'd0};
          rem    <= rem - 1'b1;
        end
      end
      B_DIGIT: begin
        if (slot_free && more_digits) begin
          digits <= {digits[DIG_W-5:0], 4'd0};
          rem    <= rem - 1'b1;
          room   <= room - 1'b1;
        end
      end
      default: begin
        digits <= digits;
      end
    endcase
  end

  // A nonzero value always has a nonzero digit ahead of the skip pointer.
  a_skip_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == B_SKIP) |-> (digits != '0) && (rem != '0))
    else $error("leading-zero skip ran out of digits");

  // The character marked last closes the run and frees the emitter.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == B_IDLE))
    else $error("emitter kept running after the closing character");

  // Only the idle emitter takes a new entry, and it never emits there.
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |=> !$past(emit))
    else $error("character emitted while idle");

endmodule

FILE: sv/u64_to_decimal_text_top.sv
// Top level of the unsigned binary to decimal ASCII text converter.
// Depends on u64dt_pkg, u64dt_front, u64dt_queue and u64dt_back.
//
// Usage:
//   Values enter on the s_ stream channel (s_tdata holds number_value). Each value
//   leaves as a run of ASCII characters on the m_ stream channel, most
//   significant digit first, closed by a NUL character; m_tlast marks the final
//   character of each run. The run, terminator included, never exceeds the
//   output_capacity register; digits that do not fit are dropped from the tail.
//   A capacity of zero produces no characters at all for that value.
//   output_capacity is written through the APB port at byte address 0 and is
//   sampled when a value is accepted. It resets to 21, enough for any value.
//
// Timing:
//   The converter runs one shift-and-add-3 step per cycle and takes no new value
//   until the current one has been through the accepting idle state, the
//   conversion steps and the hand-off of the result to the queue. With the
//   emitter free, a zero value goes straight to its first character, while
//   other values wait while the emitter steps over their leading zero digits.
//   s_tready is low while a value converts; the two-entry queue lets conversion
//   go on while a stalled receiver holds the emitter, and only a full queue
//   keeps s_tready low longer. Characters stay stable while m_tready is low.
//   Reset is synchronous and leaves the block empty and ready.
module u64_to_decimal_text_top #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // [63:0] number_value
  // Output stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [u64dt_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] text_char
  output logic                          m_tlast,   // last_char
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          paddr,
  input  logic [u64dt_pkg::APB_W-1:0]   pwdata,
  output logic [u64dt_pkg::APB_W-1:0]   prdata,
  output logic                          pready
);
  import u64dt_pkg::*;

  localparam int unsigned NDIG    = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned ENTRY_W = 4 * NDIG + CAP_W + 1;

  logic [CAP_W-1:0]   capacity;
  logic               fq_valid;
  logic               fq_ready;
  logic [ENTRY_W-1:0] fq_data;
  logic               qb_valid;
  logic               qb_ready;
  logic [ENTRY_W-1:0] qb_data;

  // The register port never waits; reads return the capacity zero-extended.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? {{(APB_W-CAP_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  u64dt_front #(
    .VALUE_BITS (VALUE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (s_tdata),
    .capacity (capacity),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  u64dt_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  u64dt_back #(
    .VALUE_BITS (VALUE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
